FILE: hdl/lgmt_pkg.sv
// Shared types, widths, codes and reset values for the landmark gate and merge table.
package lgmt_pkg;

    localparam int DEFAULT_MAX_LANDMARKS = 64;

    localparam int COORD_W     = 16;
    localparam int HIT_W       = 16;
    localparam int RADIUS_W    = 32;
    localparam int SQ_W        = 32;
    localparam int STATUS_W    = 2;
    localparam int MATCHED_W   = 7;
    localparam int NEW_INDEX_W = 6;
    localparam int TOTAL_W     = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int DIV_NUM_W  = 34;
    localparam int DIV_MAG_W  = 32;
    localparam int DIV_DEN_W  = 17;
    localparam int DIV_STEP_W = 5;

    localparam logic signed [COORD_W-1:0] X_MIN_RST = -16'sd384;
    localparam logic signed [COORD_W-1:0] X_MAX_RST = 16'sd2560;
    localparam logic signed [COORD_W-1:0] Y_MIN_RST = -16'sd2048;
    localparam logic signed [COORD_W-1:0] Y_MAX_RST = 16'sd384;
    localparam logic signed [COORD_W-1:0] Z_MIN_RST = 16'sd0;
    localparam logic signed [COORD_W-1:0] Z_MAX_RST = 16'sd205;
    localparam logic [RADIUS_W-1:0]       RADIUS_RST = 32'd262144;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_REJECTED,
        STATUS_MERGED,
        STATUS_ADDED,
        STATUS_FULL
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_X_MIN,
        CFG_X_MAX,
        CFG_Y_MIN,
        CFG_Y_MAX,
        CFG_Z_MIN,
        CFG_Z_MAX,
        CFG_RADIUS
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIST,
        ST_CMP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_WRITE,
        ST_FINISH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [HIT_W-1:0]          hits;
    } entry_t;

endpackage

FILE: hdl/lgmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lgmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                            clk,
    input  logic                                            we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
    input  logic [WIDTH-1:0]                                wdata,
    input  logic                                            re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
    output logic [WIDTH-1:0]                                rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hdl/lgmt_div.sv
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
module lgmt_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [lgmt_pkg::DIV_NUM_W-1:0]  num,
    input  logic [lgmt_pkg::DIV_DEN_W-1:0]         den,
    output logic                                   done,
    output logic signed [lgmt_pkg::COORD_W-1:0]    quotient
);
    import lgmt_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic                  neg_reg;
    logic [DIV_MAG_W-1:0]  quo_reg;
    logic [DIV_DEN_W-1:0]  rem_reg;
    logic [DIV_DEN_W-1:0]  den_reg;

    logic [DIV_NUM_W-1:0]  mag;
    logic [DIV_DEN_W:0]    trial;
    logic                  fits;
    logic [COORD_W-1:0]    quo_low;

    assign mag     = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
    assign trial   = {rem_reg, quo_reg[DIV_MAG_W-1]};
    assign fits    = trial >= {1'b0, den_reg};
    assign quo_low = quo_reg[COORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(DIV_MAG_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag[DIV_MAG_W-1:0];
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[DIV_NUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_MAG_W-2:0], fits};
            rem_reg <= fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(-quo_low) : $signed(quo_low);
endmodule

FILE: hdl/landmark_gate_merge_table.sv
// Landmark gate and merge table: box gate, radius match, running-mean merge, append.
// Sequence: a box-rejected transaction goes straight to the result register; otherwise
// each stored entry takes a RAM read, a squaring stage and a compare, and each matched
// entry also takes the 32-step serial divider and a write-back.
// Throughput: one transaction in flight; the next is taken once its result is loaded.
// Reset restores the box and radius defaults and empties the table; no clearing pass.
module landmark_gate_merge_table #(
    parameter int MAX_LANDMARKS = lgmt_pkg::DEFAULT_MAX_LANDMARKS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lgmt_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [lgmt_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   obs_valid,
    output logic                                   obs_ready,
    input  logic signed [lgmt_pkg::COORD_W-1:0]    obs_x,
    input  logic signed [lgmt_pkg::COORD_W-1:0]    obs_y,
    input  logic signed [lgmt_pkg::COORD_W-1:0]    obs_z,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output logic [lgmt_pkg::STATUS_W-1:0]          status,
    output logic [lgmt_pkg::MATCHED_W-1:0]         matched_count,
    output logic [lgmt_pkg::NEW_INDEX_W-1:0]       new_index,
    output logic [lgmt_pkg::TOTAL_W-1:0]           landmark_total
);
    import lgmt_pkg::*;

    localparam int IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int NUM_W = $clog2(MAX_LANDMARKS + 1);
    localparam int ENTRY_W = $bits(entry_t);

    logic signed [COORD_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic signed [COORD_W-1:0] z_min_reg, z_max_reg;
    logic [RADIUS_W-1:0]       radius_reg;

    state_t            state_reg, state_next;
    logic [NUM_W-1:0]  idx_reg, idx_next;
    logic [NUM_W-1:0]  used_reg, used_next;
    logic [NUM_W-1:0]  matched_reg, matched_next;
    logic [NUM_W-1:0]  new_idx_reg, new_idx_next;
    status_t           status_reg, status_next;

    logic signed [COORD_W-1:0]   obs_x_reg, obs_y_reg;
    logic [SQ_W-1:0]             sq_x_reg, sq_y_reg;
    logic [HIT_W-1:0]            hits_reg;
    logic [DIV_DEN_W-1:0]        den_reg;
    logic signed [DIV_NUM_W-1:0] num_x_reg, num_y_reg;

    logic                   res_valid_reg;
    status_t                status_out_reg;
    logic [MATCHED_W-1:0]   matched_out_reg;
    logic [NEW_INDEX_W-1:0] new_index_out_reg;
    logic [TOTAL_W-1:0]     total_out_reg;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wentry;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;

    logic                        div_start;
    logic                        div_x_done, div_y_done;
    logic signed [COORD_W-1:0]   div_x_q, div_y_q;

    logic                        in_box;
    logic                        out_load;
    logic [NUM_W-1:0]            idx_inc;
    logic                        idx_last;
    logic signed [DIV_DEN_W-1:0] dx, dy;
    logic signed [2*DIV_DEN_W-1:0] dx_sq, dy_sq;
    logic [SQ_W:0]               dist_sum;
    logic                        is_match;
    logic signed [DIV_DEN_W-1:0] hits_s;
    logic signed [DIV_NUM_W-1:0] prod_x, prod_y;

    assign in_box = obs_x >= x_min_reg && obs_x <= x_max_reg &&
                    obs_y >= y_min_reg && obs_y <= y_max_reg &&
                    obs_z >= z_min_reg && obs_z <= z_max_reg;

    assign rd_entry = ram_rdata;
    assign dx       = DIV_DEN_W'(obs_x_reg) - DIV_DEN_W'(rd_entry.x);
    assign dy       = DIV_DEN_W'(obs_y_reg) - DIV_DEN_W'(rd_entry.y);
    assign dx_sq    = dx * dx;
    assign dy_sq    = dy * dy;
    assign dist_sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign is_match = dist_sum <= {1'b0, radius_reg};
    assign hits_s   = {1'b0, hits_reg};
    assign prod_x   = rd_entry.x * hits_s;
    assign prod_y   = rd_entry.y * hits_s;
    assign idx_inc  = idx_reg + NUM_W'(1);
    assign idx_last = idx_inc == used_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg  <= X_MIN_RST;
            x_max_reg  <= X_MAX_RST;
            y_min_reg  <= Y_MIN_RST;
            y_max_reg  <= Y_MAX_RST;
            z_min_reg  <= Z_MIN_RST;
            z_max_reg  <= Z_MAX_RST;
            radius_reg <= RADIUS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_X_MIN:  x_min_reg  <= cfg_data[COORD_W-1:0];
                CFG_X_MAX:  x_max_reg  <= cfg_data[COORD_W-1:0];
                CFG_Y_MIN:  y_min_reg  <= cfg_data[COORD_W-1:0];
                CFG_Y_MAX:  y_max_reg  <= cfg_data[COORD_W-1:0];
                CFG_Z_MIN:  z_min_reg  <= cfg_data[COORD_W-1:0];
                CFG_Z_MAX:  z_max_reg  <= cfg_data[COORD_W-1:0];
                CFG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                default:    ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            used_reg    <= '0;
            matched_reg <= '0;
            new_idx_reg <= '0;
            status_reg  <= STATUS_REJECTED;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            used_reg    <= used_next;
            matched_reg <= matched_next;
            new_idx_reg <= new_idx_next;
            status_reg  <= status_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        used_next    = used_reg;
        matched_next = matched_reg;
        new_idx_next = new_idx_reg;
        status_next  = status_reg;
        ram_re       = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[IDX_W-1:0];
        ram_wentry   = '{x: div_x_q, y: div_y_q, hits: hits_reg};
        div_start    = 1'b0;
        out_load     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (obs_valid)
                begin
                    idx_next     = '0;
                    matched_next = '0;
                    new_idx_next = '0;
                    if (!in_box)
                    begin
                        status_next = STATUS_REJECTED;
                        state_next  = ST_RESULT;
                    end
                    else if (used_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (is_match)
                begin
                    state_next = ST_MUL;
                end
                else if (idx_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_READ;
                end
            end
            ST_MUL:
            begin
                matched_next = matched_reg + NUM_W'(1);
                state_next   = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_x_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ram_we = 1'b1;
                if (idx_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_READ;
                end
            end
            ST_FINISH:
            begin
                if (matched_reg != '0)
                begin
                    status_next = STATUS_MERGED;
                end
                else if (used_reg < NUM_W'(MAX_LANDMARKS))
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = used_reg[IDX_W-1:0];
                    ram_wentry   = '{x: obs_x_reg, y: obs_y_reg, hits: '0};
                    new_idx_next = used_reg;
                    used_next    = used_reg + NUM_W'(1);
                    status_next  = STATUS_ADDED;
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign obs_ready = state_reg == ST_IDLE;

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && obs_valid)
        begin
            obs_x_reg <= obs_x;
            obs_y_reg <= obs_y;
        end
        if (state_reg == ST_DIST)
        begin
            sq_x_reg <= dx_sq[SQ_W-1:0];
            sq_y_reg <= dy_sq[SQ_W-1:0];
        end
        if (state_reg == ST_CMP)
        begin
            hits_reg <= (rd_entry.hits == HIT_MAX) ? HIT_MAX : rd_entry.hits + HIT_W'(1);
        end
        if (state_reg == ST_MUL)
        begin
            num_x_reg <= prod_x + DIV_NUM_W'(obs_x_reg);
            num_y_reg <= prod_y + DIV_NUM_W'(obs_y_reg);
            den_reg   <= {1'b0, hits_reg} + DIV_DEN_W'(1);
        end
    end

    lgmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LANDMARKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    lgmt_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_x_reg),
        .den      (den_reg),
        .done     (div_x_done),
        .quotient (div_x_q)
    );

    lgmt_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_y_reg),
        .den      (den_reg),
        .done     (div_y_done),
        .quotient (div_y_q)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_out_reg    <= status_reg;
            matched_out_reg   <= MATCHED_W'(matched_reg);
            new_index_out_reg <= NEW_INDEX_W'(new_idx_reg);
            total_out_reg     <= TOTAL_W'(used_reg);
        end
    end

    assign res_valid      = res_valid_reg;
    assign status         = status_out_reg;
    assign matched_count  = matched_out_reg;
    assign new_index      = new_index_out_reg;
    assign landmark_total = total_out_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= NUM_W'(MAX_LANDMARKS))
        else $error("entry count beyond table depth");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_x_done == div_y_done)
        else $error("x and y dividers out of step");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_WRITE || state_reg == ST_FINISH))
        else $error("table write outside write-back or append");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (obs_valid && obs_ready) |=> !obs_ready)
        else $error("second transaction taken while one is in flight");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> res_valid)
        else $error("result load did not raise valid");
endmodule
